// File: rtl/jsesc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsesc_pkg;

    localparam int HOLD_DEPTH  = 6;
    localparam int CNT_W       = 3;
    localparam int SEQ_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CTRL_MAX  = 8'h1F;

    typedef enum logic [1:0] {
        ESC_PASS,
        ESC_SHORT,
        ESC_LONG
    } t_esc_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_esc_kind  kind;
        logic [7:0] code;
    } t_item;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
    endfunction

    function automatic logic [7:0] simple_unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_B:    r = 8'h08;
            CH_F:    r = 8'h0C;
            CH_N:    r = 8'h0A;
            CH_R:    r = 8'h0D;
            CH_T:    r = 8'h09;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/jsesc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jsesc_front (
    input  wire logic               i_in_valid,
    input  wire logic [7:0]         i_in_byte,
    input  wire logic               i_in_last,
    input  wire logic               i_full,
    output logic                    o_in_stall,
    output logic                    o_push,
    output jsesc_pkg::t_item        o_item
);

    logic [7:0] code;

    always_comb begin
        case (i_in_byte)
            jsesc_pkg::CH_QUOTE:  code = jsesc_pkg::CH_QUOTE;
            jsesc_pkg::CH_BSLASH: code = jsesc_pkg::CH_BSLASH;
            8'h08:                code = jsesc_pkg::CH_B;
            8'h0C:                code = jsesc_pkg::CH_F;
            8'h0A:                code = jsesc_pkg::CH_N;
            8'h0D:                code = jsesc_pkg::CH_R;
            8'h09:                code = jsesc_pkg::CH_T;
            default:              code = 8'h00;
        endcase
    end

    always_comb begin
        o_item.data = i_in_byte;
        o_item.last = i_in_last;
        o_item.code = code;
        if (code != 8'h00) begin
            o_item.kind = jsesc_pkg::ESC_SHORT;
        end else if (i_in_byte <= jsesc_pkg::CTRL_MAX) begin
            o_item.kind = jsesc_pkg::ESC_LONG;
        end else begin
            o_item.kind = jsesc_pkg::ESC_PASS;
        end
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

`default_nettype wire

// File: rtl/jsesc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module jsesc_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire jsesc_pkg::t_item   i_item,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output jsesc_pkg::t_item        o_head
);

    jsesc_pkg::t_item                  r_mem [jsesc_pkg::QUEUE_DEPTH];
    logic [jsesc_pkg::QUEUE_AW-1:0]    r_wr;
    logic [jsesc_pkg::QUEUE_AW-1:0]    r_rd;
    logic [jsesc_pkg::QUEUE_AW:0]      r_cnt;
    logic [jsesc_pkg::QUEUE_AW-1:0]    n_wr;
    logic [jsesc_pkg::QUEUE_AW-1:0]    n_rd;
    logic [jsesc_pkg::QUEUE_AW:0]      n_cnt;

    assign o_full  = (r_cnt == (jsesc_pkg::QUEUE_AW+1)'(jsesc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + {{jsesc_pkg::QUEUE_AW{1'b0}}, i_push}
                      - {{jsesc_pkg::QUEUE_AW{1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    overflow_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    underflow_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    count_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (jsesc_pkg::QUEUE_AW+1)'(jsesc_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// File: rtl/jsesc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jsesc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_dir,
    input  wire logic               i_clear,
    input  wire logic               i_empty,
    input  wire jsesc_pkg::t_item   i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    output logic [7:0]              o_out_byte,
    output logic                    o_out_last,
    input  wire logic               i_out_stall
);

    logic [7:0]                   r_held [jsesc_pkg::HOLD_DEPTH];
    logic [7:0]                   n_held [jsesc_pkg::HOLD_DEPTH];
    logic [jsesc_pkg::CNT_W-1:0]  r_cnt;
    logic [jsesc_pkg::CNT_W-1:0]  n_cnt;
    logic                         r_scan;
    logic                         n_scan;
    logic                         r_scan_last;
    logic                         n_scan_last;
    logic [jsesc_pkg::SEQ_W-1:0]  r_seq;
    logic [jsesc_pkg::SEQ_W-1:0]  n_seq;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [7:0]                   r_out_byte;
    logic [7:0]                   n_out_byte;
    logic                         r_out_last;
    logic                         n_out_last;

    logic [7:0]                   v   [jsesc_pkg::HOLD_DEPTH];
    logic [7:0]                   sh1 [jsesc_pkg::HOLD_DEPTH];
    logic [7:0]                   sh2 [jsesc_pkg::HOLD_DEPTH];
    logic [jsesc_pkg::CNT_W-1:0]  c;
    logic                         scan_l;
    logic                         any_bad;
    logic                         st_emit;
    logic [7:0]                   st_byte;
    logic [jsesc_pkg::CNT_W-1:0]  st_k;
    logic [jsesc_pkg::CNT_W-1:0]  rem;
    logic [7:0]                   esc_byte;
    logic                         esc_final;
    logic                         slot_free;
    logic                         load;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int i = 0; i < jsesc_pkg::HOLD_DEPTH; i++) begin
            v[i] = (!r_scan && (jsesc_pkg::CNT_W'(i) == r_cnt)) ? i_head.data : r_held[i];
        end
        for (int i = 0; i < jsesc_pkg::HOLD_DEPTH - 1; i++) begin
            sh1[i] = v[i+1];
        end
        sh1[jsesc_pkg::HOLD_DEPTH-1] = v[jsesc_pkg::HOLD_DEPTH-1];
        for (int i = 0; i < jsesc_pkg::HOLD_DEPTH - 2; i++) begin
            sh2[i] = v[i+2];
        end
        sh2[jsesc_pkg::HOLD_DEPTH-2] = v[jsesc_pkg::HOLD_DEPTH-2];
        sh2[jsesc_pkg::HOLD_DEPTH-1] = v[jsesc_pkg::HOLD_DEPTH-1];
        c      = r_scan ? r_cnt : r_cnt + 1'b1;
        scan_l = r_scan ? r_scan_last : i_head.last;
        any_bad = 1'b0;
        for (int i = 2; i < jsesc_pkg::HOLD_DEPTH; i++) begin
            if (jsesc_pkg::CNT_W'(i) < c && !jsesc_pkg::is_hex(v[i])) begin
                any_bad = 1'b1;
            end
        end
    end

    always_comb begin
        st_emit = 1'b0;
        st_byte = v[0];
        st_k    = jsesc_pkg::CNT_W'(1);
        if (c == '0) begin
            st_emit = 1'b0;
        end else if (v[0] != jsesc_pkg::CH_BSLASH) begin
            st_emit = 1'b1;
        end else if (c < jsesc_pkg::CNT_W'(2)) begin
            st_emit = scan_l;
            st_byte = jsesc_pkg::CH_BSLASH;
        end else if (v[1] != jsesc_pkg::CH_U) begin
            st_emit = 1'b1;
            st_byte = jsesc_pkg::simple_unescape(v[1]);
            st_k    = jsesc_pkg::CNT_W'(2);
        end else if (any_bad || (c < jsesc_pkg::CNT_W'(jsesc_pkg::HOLD_DEPTH) && scan_l)) begin
            st_emit = 1'b1;
            st_byte = jsesc_pkg::CH_U;
            st_k    = jsesc_pkg::CNT_W'(2);
        end else if (c == jsesc_pkg::CNT_W'(jsesc_pkg::HOLD_DEPTH)) begin
            st_emit = 1'b1;
            st_byte = {jsesc_pkg::hex_val(v[4]), jsesc_pkg::hex_val(v[5])};
            st_k    = jsesc_pkg::CNT_W'(jsesc_pkg::HOLD_DEPTH);
        end
        rem = c - st_k;
    end

    always_comb begin
        esc_byte  = i_head.data;
        esc_final = 1'b1;
        case (i_head.kind)
            jsesc_pkg::ESC_SHORT: begin
                esc_byte  = (r_seq == '0) ? jsesc_pkg::CH_BSLASH : i_head.code;
                esc_final = (r_seq == jsesc_pkg::SEQ_W'(1));
            end
            jsesc_pkg::ESC_LONG: begin
                case (r_seq)
                    3'd0:    esc_byte = jsesc_pkg::CH_BSLASH;
                    3'd1:    esc_byte = jsesc_pkg::CH_U;
                    3'd2:    esc_byte = jsesc_pkg::CH_ZERO;
                    3'd3:    esc_byte = jsesc_pkg::CH_ZERO;
                    3'd4:    esc_byte = jsesc_pkg::hex_char(i_head.data[7:4]);
                    default: esc_byte = jsesc_pkg::hex_char(i_head.data[3:0]);
                endcase
                esc_final = (r_seq == jsesc_pkg::SEQ_W'(5));
            end
            default: begin
                esc_byte  = i_head.data;
                esc_final = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_held      = r_held;
        n_cnt       = r_cnt;
        n_scan      = r_scan;
        n_scan_last = r_scan_last;
        n_seq       = r_seq;
        load        = 1'b0;
        o_pop       = 1'b0;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (!i_dir) begin
            if (!i_empty && slot_free) begin
                load       = 1'b1;
                n_out_byte = esc_byte;
                n_out_last = i_head.last && esc_final;
                if (esc_final) begin
                    o_pop = 1'b1;
                    n_seq = '0;
                end else begin
                    n_seq = r_seq + 1'b1;
                end
            end
        end else if (r_scan || !i_empty) begin
            if (st_emit) begin
                if (slot_free) begin
                    load        = 1'b1;
                    o_pop       = !r_scan;
                    n_out_byte  = st_byte;
                    n_out_last  = scan_l && (rem == '0);
                    n_cnt       = rem;
                    n_scan      = (rem != '0);
                    n_scan_last = scan_l;
                    if (st_k == jsesc_pkg::CNT_W'(1)) begin
                        n_held = sh1;
                    end else begin
                        n_held = sh2;
                    end
                end
            end else if (!r_scan) begin
                o_pop  = 1'b1;
                n_held = v;
                n_cnt  = c;
                n_scan = 1'b0;
            end else begin
                n_scan = 1'b0;
            end
        end
        if (i_clear) begin
            n_cnt  = '0;
            n_scan = 1'b0;
            n_seq  = '0;
        end
        n_out_valid = load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_scan      <= 1'b0;
            r_scan_last <= 1'b0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_scan      <= n_scan;
            r_scan_last <= n_scan_last;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
        r_held     <= n_held;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    hold_range_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= jsesc_pkg::CNT_W'(jsesc_pkg::HOLD_DEPTH - 1))
        else $error("held count out of range");

    escape_no_hold_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_dir |-> (r_cnt == '0 && !r_scan))
        else $error("held bytes in escape mode");

    seq_mode_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != '0) |-> !i_dir)
        else $error("escape sequence active in unescape mode");

    scan_nonempty_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan |-> (r_cnt != '0))
        else $error("scan active with nothing held");

    last_flush_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_out_last && i_dir && !i_clear) |=> (r_cnt == '0 && !r_scan))
        else $error("string end left bytes held");

endmodule

`default_nettype wire

// File: rtl/json_string_escape_unescape.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                   Transfer when
// in        i_in_valid, o_in_stall, i_in_byte/last    i_in_valid && !o_in_stall
// out       o_out_valid, i_out_stall, o_out_byte/last o_out_valid && !i_out_stall
// cfg       i_cfg_valid, o_cfg_ready, i_cfg_direction i_cfg_valid && o_cfg_ready
//
// Escape mode: one output byte per cycle from the back-end sequencer unless stalled;
// an input byte becomes 1, 2 or 6 output bytes. Unescape mode: one emitted byte per
// cycle unless stalled; a byte that only joins the hold buffer emits nothing, and a
// rescan that stops on bytes still held emits nothing. Two-entry queue sits between
// front and back. Reset is synchronous, active low, and clears queue, hold count and
// output valid. Output stall holds the output register and backs up into the queue.

module json_string_escape_unescape (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_direction
);

    logic                r_direction;
    logic                n_direction;
    logic                cfg_wr;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    jsesc_pkg::t_item    front_item;
    jsesc_pkg::t_item    head_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign n_direction = cfg_wr ? i_cfg_direction : r_direction;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else begin
            r_direction <= n_direction;
        end
    end

    jsesc_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_item     (front_item)
    );

    jsesc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_item)
    );

    jsesc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dir       (r_direction),
        .i_clear     (cfg_wr),
        .i_empty     (empty),
        .i_head      (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
